FILE: design/wavp_pkg.sv
// Package for the WAV PCM16 stream parser: request types, chunk ids,
// error codes and configuration constants. No dependencies.
`timescale 1ns / 1ps

package wavp_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 1'd1;

    localparam logic [31:0] RATE_RESET     = 32'd16000;
    localparam logic [15:0] CHANNELS_RESET = 16'd1;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [15:0] PCM_CODE  = 16'd1;
    localparam logic [15:0] NEED_BITS = 16'd16;
    localparam logic [31:0] FMT_MIN   = 32'd16;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_RIFF      = 4'd1;
    localparam logic [3:0] ERR_WAVE      = 4'd2;
    localparam logic [3:0] ERR_FMT_SMALL = 4'd3;
    localparam logic [3:0] ERR_DATA_1ST  = 4'd4;
    localparam logic [3:0] ERR_NOT_PCM   = 4'd5;
    localparam logic [3:0] ERR_CHANNELS  = 4'd6;
    localparam logic [3:0] ERR_BITS      = 4'd7;
    localparam logic [3:0] ERR_RATE      = 4'd8;
    localparam logic [3:0] ERR_ODD_SIZE  = 4'd9;
    localparam logic [3:0] ERR_TRUNC     = 4'd10;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               sample_valid;
        logic               finished;
        logic [3:0]         error_code;
    } t_out_req;

    typedef struct packed {
        logic     valid;
        t_out_req req;
    } t_parse_res;

endpackage

FILE: design/wavp_parse.sv
// Byte-wise RIFF/WAVE chunk walker: parse state registers and the
// per-byte next-state and result logic. Depends on wavp_pkg.
`timescale 1ns / 1ps

module wavp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  wavp_pkg::t_in_req   i_in_req,
    input  logic [31:0]         i_exp_rate,
    input  logic [15:0]         i_exp_channels,
    output wavp_pkg::t_parse_res o_res
);

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHID, PH_CHSIZE, PH_FCODE, PH_FCHAN,
        PH_FRATE, PH_FBRATE, PH_FALIGN, PH_FBITS, PH_SKIP, PH_PAD, PH_DATA,
        PH_DONE, PH_ERR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_chunk_id, n_chunk_id;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic        r_odd, n_odd;
    logic [15:0] r_fcode, n_fcode;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic        r_fmt_found, n_fmt_found;
    logic [7:0]  r_low, n_low;

    logic [31:0] w_value;
    logic [2:0]  w_idx_inc;
    logic        w_done2, w_done4;
    logic [7:0]  w_b;

    assign w_b       = i_in_req.data_byte;
    assign w_idx_inc = r_idx + 3'd1;
    assign w_done2   = (w_idx_inc >= 3'd2);
    assign w_done4   = (w_idx_inc >= 3'd4);

    always_comb begin
        case (r_idx[1:0])
            2'd0:    w_value = r_shift | {24'd0, w_b};
            2'd1:    w_value = r_shift | {16'd0, w_b, 8'd0};
            2'd2:    w_value = r_shift | {8'd0, w_b, 16'd0};
            default: w_value = r_shift | {w_b, 24'd0};
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_idx        = r_idx;
        n_shift      = r_shift;
        n_chunk_id   = r_chunk_id;
        n_bytes_left = r_bytes_left;
        n_odd        = r_odd;
        n_fcode      = r_fcode;
        n_chan       = r_chan;
        n_rate       = r_rate;
        n_bits       = r_bits;
        n_fmt_found  = r_fmt_found;
        n_low        = r_low;
        o_res        = '0;

        if (i_accept && r_phase != PH_DONE && r_phase != PH_ERR) begin
            if (i_in_req.opcode == wavp_pkg::OP_EOF) begin
                n_phase                = PH_ERR;
                o_res.valid            = 1'b1;
                o_res.req.error_code   = wavp_pkg::ERR_TRUNC;
            end else begin
                case (r_phase)
                    PH_RIFF, PH_RSIZE, PH_WAVE, PH_CHID, PH_CHSIZE, PH_FRATE,
                    PH_FBRATE: begin
                        n_shift = w_value;
                        n_idx   = w_idx_inc;
                        if (w_done4) begin
                            n_idx   = 3'd0;
                            n_shift = '0;
                            case (r_phase)
                                PH_RIFF: begin
                                    n_chunk_id = w_value;
                                    n_phase    = PH_RSIZE;
                                end
                                PH_RSIZE:  n_phase = PH_WAVE;
                                PH_WAVE: begin
                                    n_phase = PH_CHID;
                                    if (r_chunk_id != wavp_pkg::ID_RIFF) begin
                                        n_phase              = PH_ERR;
                                        o_res.valid          = 1'b1;
                                        o_res.req.error_code = wavp_pkg::ERR_RIFF;
                                    end else if (w_value != wavp_pkg::ID_WAVE) begin
                                        n_phase              = PH_ERR;
                                        o_res.valid          = 1'b1;
                                        o_res.req.error_code = wavp_pkg::ERR_WAVE;
                                    end
                                end
                                PH_CHID: begin
                                    n_chunk_id = w_value;
                                    n_phase    = PH_CHSIZE;
                                end
                                PH_FRATE: begin
                                    n_rate  = w_value;
                                    n_phase = PH_FBRATE;
                                end
                                PH_FBRATE: n_phase = PH_FALIGN;
                                default: begin
                                    // chunk size complete
                                    n_odd        = w_value[0];
                                    n_bytes_left = w_value;
                                    if (r_chunk_id == wavp_pkg::ID_FMT) begin
                                        n_bytes_left = w_value - wavp_pkg::FMT_MIN;
                                        n_phase      = PH_FCODE;
                                        if (w_value < wavp_pkg::FMT_MIN) begin
                                            n_phase              = PH_ERR;
                                            o_res.valid          = 1'b1;
                                            o_res.req.error_code =
                                                wavp_pkg::ERR_FMT_SMALL;
                                        end
                                    end else if (r_chunk_id == wavp_pkg::ID_DATA) begin
                                        n_phase     = PH_ERR;
                                        o_res.valid = 1'b1;
                                        if (!r_fmt_found)
                                            o_res.req.error_code =
                                                wavp_pkg::ERR_DATA_1ST;
                                        else if (r_fcode != wavp_pkg::PCM_CODE)
                                            o_res.req.error_code =
                                                wavp_pkg::ERR_NOT_PCM;
                                        else if (r_chan != i_exp_channels)
                                            o_res.req.error_code =
                                                wavp_pkg::ERR_CHANNELS;
                                        else if (r_bits != wavp_pkg::NEED_BITS)
                                            o_res.req.error_code = wavp_pkg::ERR_BITS;
                                        else if (r_rate != i_exp_rate)
                                            o_res.req.error_code = wavp_pkg::ERR_RATE;
                                        else if (w_value[0])
                                            o_res.req.error_code =
                                                wavp_pkg::ERR_ODD_SIZE;
                                        else if (w_value == '0) begin
                                            n_phase            = PH_DONE;
                                            o_res.req.finished = 1'b1;
                                        end else begin
                                            n_phase     = PH_DATA;
                                            o_res.valid = 1'b0;
                                        end
                                    end else if (w_value == '0) begin
                                        n_phase = PH_CHID;
                                    end else begin
                                        n_phase = PH_SKIP;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_FCODE, PH_FCHAN, PH_FALIGN, PH_FBITS: begin
                        n_shift = w_value;
                        n_idx   = w_idx_inc;
                        if (w_done2) begin
                            n_idx   = 3'd0;
                            n_shift = '0;
                            case (r_phase)
                                PH_FCODE: begin
                                    n_fcode = w_value[15:0];
                                    n_phase = PH_FCHAN;
                                end
                                PH_FCHAN: begin
                                    n_chan  = w_value[15:0];
                                    n_phase = PH_FRATE;
                                end
                                PH_FALIGN: n_phase = PH_FBITS;
                                default: begin
                                    n_bits      = w_value[15:0];
                                    n_fmt_found = 1'b1;
                                    if (r_bytes_left != '0)
                                        n_phase = PH_SKIP;
                                    else
                                        n_phase = r_odd ? PH_PAD : PH_CHID;
                                end
                            endcase
                        end
                    end
                    PH_SKIP: begin
                        n_bytes_left = r_bytes_left - 32'd1;
                        if (r_bytes_left == 32'd1)
                            n_phase = r_odd ? PH_PAD : PH_CHID;
                    end
                    PH_PAD: n_phase = PH_CHID;
                    PH_DATA: begin
                        n_bytes_left = r_bytes_left - 32'd1;
                        if (r_idx == 3'd0) begin
                            n_low = w_b;
                            n_idx = 3'd1;
                        end else begin
                            n_idx                  = 3'd0;
                            o_res.valid            = 1'b1;
                            o_res.req.sample       = {w_b, r_low};
                            o_res.req.sample_valid = 1'b1;
                            if (r_bytes_left == 32'd1) begin
                                n_phase            = PH_DONE;
                                o_res.req.finished = 1'b1;
                            end
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_RIFF;
            r_idx        <= '0;
            r_shift      <= '0;
            r_chunk_id   <= '0;
            r_bytes_left <= '0;
            r_odd        <= 1'b0;
            r_fcode      <= '0;
            r_chan       <= '0;
            r_rate       <= '0;
            r_bits       <= '0;
            r_fmt_found  <= 1'b0;
            r_low        <= '0;
        end else begin
            r_phase      <= n_phase;
            r_idx        <= n_idx;
            r_shift      <= n_shift;
            r_chunk_id   <= n_chunk_id;
            r_bytes_left <= n_bytes_left;
            r_odd        <= n_odd;
            r_fcode      <= n_fcode;
            r_chan       <= n_chan;
            r_rate       <= n_rate;
            r_bits       <= n_bits;
            r_fmt_found  <= n_fmt_found;
            r_low        <= n_low;
        end
    end

endmodule

FILE: design/wav_pcm16_stream_parser_core.sv
// Top level of the WAV PCM16 stream parser: handshake, configuration
// registers and the result register. Depends on wavp_pkg and wavp_parse.
//
//   channel   direction   signals                               payload
//   in        sink        i_in_valid / o_in_stall               i_in_req  (t_in_req)
//   out       source      o_out_valid / i_out_stall             o_out_req (t_out_req)
//   cfg       sink        i_cfg_we / i_cfg_index                i_cfg_data
//
// One byte request per cycle while the input does not stall; a byte's result, if
// any, is registered and shows on the next cycle from the result register.
// A synchronous low on i_rst_n restores the parser and the registers
// (rate 16000, one channel). The input stalls only while a result sits
// in the result register and the output side stalls.
`timescale 1ns / 1ps

module wav_pcm16_stream_parser_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  wavp_pkg::t_in_req                    i_in_req,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output wavp_pkg::t_out_req                   o_out_req,
    input  logic                                 i_cfg_we,
    input  logic [wavp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wavp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [31:0]          r_exp_rate;
    logic [15:0]          r_exp_channels;
    logic                 r_out_valid;
    wavp_pkg::t_out_req   r_out_req;
    wavp_pkg::t_parse_res w_res;
    logic                 w_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    wavp_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_in_req       (i_in_req),
        .i_exp_rate     (r_exp_rate),
        .i_exp_channels (r_exp_channels),
        .o_res          (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_rate     <= wavp_pkg::RATE_RESET;
            r_exp_channels <= wavp_pkg::CHANNELS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wavp_pkg::CFG_SAMPLE_RATE: r_exp_rate     <= i_cfg_data[31:0];
                wavp_pkg::CFG_CHANNELS:    r_exp_channels <= i_cfg_data[15:0];
                default:                   r_exp_rate     <= r_exp_rate;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_out_valid <= w_accept && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_out_req <= w_res.req;
        end
    end

endmodule
